// File: design/entity_id_allocator_macros.svh
// ----------------------------------------------------------------------------
// Entity ID allocator assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ENTITY_ID_ALLOCATOR_MACROS_SVH
`define ENTITY_ID_ALLOCATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
`define EIA_ASSERT_SAME(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);
`define EIA_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);
`else
`define EIA_ASSERT_SAME(lbl, ant, cons, msg)
`define EIA_ASSERT_NEXT(lbl, ant, cons, msg)
`endif

`endif

// File: design/eia_pkg.sv
// ----------------------------------------------------------------------------
// Entity ID allocator package
// Sizes, operation and status codes, and request and response types.
// ----------------------------------------------------------------------------
package eia_pkg;

  localparam int MAX_ENTITIES = 1024;
  localparam int ID_W         = $clog2(MAX_ENTITIES);
  localparam int CNT_W        = $clog2(MAX_ENTITIES + 1);
  localparam int MASK_W       = 32;

  localparam logic [1:0] OP_CREATE   = 2'd0;
  localparam logic [1:0] OP_DESTROY  = 2'd1;
  localparam logic [1:0] OP_RESET    = 2'd2;
  localparam logic [1:0] OP_SET_MASK = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ID_W-1:0]   entity;
    logic [MASK_W-1:0] mask_value;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]  entity_id;
    logic [1:0]       status;
    logic [CNT_W-1:0] alive_count;
  } rsp_t;

endpackage

// File: design/eia_ram.sv
// ----------------------------------------------------------------------------
// Entity ID allocator RAM
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module eia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/entity_id_allocator.sv
// ----------------------------------------------------------------------------
// Entity ID allocator
// Hands out entity indices from a LIFO free stack, falling back to a bump
// pointer, and keeps a component mask for each index.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Payload
//  in       input      in_valid/in_stall  eia_pkg::req_t
//  out      output     out_valid/out_stall eia_pkg::rsp_t
//  cfg      input      cfg_valid/cfg_ready capacity, 11 bits
//
//  Each request first reads the mask and stack memories, then decides,
//  writes back and loads the output register.
//  A request is taken while a previous response still waits in the output
//  register; it then holds in the execute state until that register frees.
//  Reset clears the counters and sets the capacity to MAX_ENTITIES; no clearing pass.
// ----------------------------------------------------------------------------
`include "entity_id_allocator_macros.svh"

module entity_id_allocator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  eia_pkg::req_t              in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output eia_pkg::rsp_t              out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [eia_pkg::CNT_W-1:0]  cfg_data
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                        state_r, state_nxt;
  eia_pkg::req_t               req_r;
  logic [eia_pkg::CNT_W-1:0]   capacity_r;
  logic [eia_pkg::CNT_W-1:0]   free_depth_r, free_depth_nxt;
  logic [eia_pkg::CNT_W-1:0]   high_water_r, high_water_nxt;
  logic [eia_pkg::CNT_W-1:0]   live_count_r, live_count_nxt;
  logic                        out_valid_r, out_valid_nxt;
  eia_pkg::rsp_t               out_data_r, out_data_nxt;

  logic                        accept;
  logic                        out_free;
  logic                        fire;
  logic [eia_pkg::CNT_W-1:0]   usable;

  logic                        mask_we;
  logic [eia_pkg::ID_W-1:0]    mask_waddr;
  logic [eia_pkg::MASK_W-1:0]  mask_wdata;
  logic [eia_pkg::MASK_W-1:0]  mask_rdata;
  logic                        stack_we;
  logic [eia_pkg::ID_W-1:0]    stack_waddr;
  logic [eia_pkg::ID_W-1:0]    stack_wdata;
  logic [eia_pkg::ID_W-1:0]    stack_raddr;
  logic [eia_pkg::ID_W-1:0]    stack_rdata;
  logic                        ent_below_hw;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign fire      = (state_r == S_EXEC) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  assign stack_raddr  = eia_pkg::ID_W'(free_depth_r - eia_pkg::CNT_W'(1));
  assign ent_below_hw = eia_pkg::CNT_W'(req_r.entity) < high_water_r;

  always_comb begin
    if (capacity_r == '0 || capacity_r > eia_pkg::CNT_W'(eia_pkg::MAX_ENTITIES)) begin
      usable = eia_pkg::CNT_W'(eia_pkg::MAX_ENTITIES);
    end else begin
      usable = capacity_r;
    end
  end

  eia_ram #(
    .WIDTH (eia_pkg::MASK_W),
    .DEPTH (eia_pkg::MAX_ENTITIES)
  ) u_mask_ram (
    .clk   (clk),
    .we    (mask_we),
    .waddr (mask_waddr),
    .wdata (mask_wdata),
    .re    (accept),
    .raddr (in_data.entity),
    .rdata (mask_rdata)
  );

  eia_ram #(
    .WIDTH (eia_pkg::ID_W),
    .DEPTH (eia_pkg::MAX_ENTITIES)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (stack_wdata),
    .re    (accept),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    free_depth_nxt = free_depth_r;
    high_water_nxt = high_water_r;
    live_count_nxt = live_count_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    mask_we        = 1'b0;
    mask_waddr     = req_r.entity;
    mask_wdata     = '0;
    stack_we       = 1'b0;
    stack_waddr    = eia_pkg::ID_W'(free_depth_r);
    stack_wdata    = req_r.entity;

    if (accept) begin
      state_nxt = S_EXEC;
    end

    if (fire) begin
      state_nxt              = S_IDLE;
      out_valid_nxt          = 1'b1;
      out_data_nxt.entity_id = '0;
      out_data_nxt.status    = eia_pkg::ST_DONE;
      unique case (req_r.operation)
        eia_pkg::OP_CREATE: begin
          if (free_depth_r != '0) begin
            free_depth_nxt         = free_depth_r - eia_pkg::CNT_W'(1);
            mask_we                = 1'b1;
            mask_waddr             = stack_rdata;
            live_count_nxt         = live_count_r + eia_pkg::CNT_W'(1);
            out_data_nxt.entity_id = stack_rdata;
          end else if (high_water_r < usable) begin
            high_water_nxt         = high_water_r + eia_pkg::CNT_W'(1);
            mask_we                = 1'b1;
            mask_waddr             = eia_pkg::ID_W'(high_water_r);
            live_count_nxt         = live_count_r + eia_pkg::CNT_W'(1);
            out_data_nxt.entity_id = eia_pkg::ID_W'(high_water_r);
          end else begin
            out_data_nxt.status = eia_pkg::ST_FULL;
          end
        end
        eia_pkg::OP_DESTROY: begin
          if (ent_below_hw && mask_rdata != '0 && live_count_r != '0 &&
              free_depth_r < eia_pkg::CNT_W'(eia_pkg::MAX_ENTITIES)) begin
            mask_we        = 1'b1;
            stack_we       = 1'b1;
            free_depth_nxt = free_depth_r + eia_pkg::CNT_W'(1);
            live_count_nxt = live_count_r - eia_pkg::CNT_W'(1);
          end else begin
            out_data_nxt.status = eia_pkg::ST_IGNORED;
          end
        end
        eia_pkg::OP_RESET: begin
          free_depth_nxt = '0;
          high_water_nxt = '0;
          live_count_nxt = '0;
        end
        eia_pkg::OP_SET_MASK: begin
          if (ent_below_hw) begin
            mask_we    = 1'b1;
            mask_wdata = req_r.mask_value;
          end else begin
            out_data_nxt.status = eia_pkg::ST_IGNORED;
          end
        end
        default: begin
          out_data_nxt.status = eia_pkg::ST_IGNORED;
        end
      endcase
      out_data_nxt.alive_count = live_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      capacity_r   <= eia_pkg::CNT_W'(eia_pkg::MAX_ENTITIES);
      free_depth_r <= '0;
      high_water_r <= '0;
      live_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_depth_r <= free_depth_nxt;
      high_water_r <= high_water_nxt;
      live_count_r <= live_count_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  `EIA_ASSERT_SAME(a_balance, 1'b1, (12'(free_depth_r) + 12'(live_count_r)) == 12'(high_water_r), "free depth plus live count differs from high water")
  `EIA_ASSERT_NEXT(a_accept_exec, accept, state_r == S_EXEC, "accepted request did not enter execution")
  `EIA_ASSERT_SAME(a_hw_bound, 1'b1, high_water_r <= eia_pkg::CNT_W'(eia_pkg::MAX_ENTITIES), "high water exceeds table size")
  `EIA_ASSERT_SAME(a_id_zero, out_valid_r && out_data_r.status != eia_pkg::ST_DONE, out_data_r.entity_id == '0, "failed response carries a nonzero index")

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Entity ID allocator testbench
// Drives create, destroy, reset-all and mask-write requests through the
// allocator under several capacity settings, with random request gaps and
// response stalls, and checks every response against a cycle-free prediction
// of the free stack, high-water mark and live count.
// ----------------------------------------------------------------------------
module tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  eia_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  eia_pkg::rsp_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [eia_pkg::CNT_W-1:0] cfg_data = '0;

  entity_id_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Allocator state as the responses should see it.
  logic [eia_pkg::CNT_W-1:0]  slot_limit = eia_pkg::CNT_W'(eia_pkg::MAX_ENTITIES);
  logic [eia_pkg::MASK_W-1:0] comp_mask [eia_pkg::MAX_ENTITIES];
  logic [eia_pkg::ID_W-1:0]   free_ids [eia_pkg::MAX_ENTITIES];
  int free_depth = 0;
  int high_water = 0;
  int live_count = 0;

  eia_pkg::req_t req_queue [$];
  eia_pkg::rsp_t awaited_rsp [$];
  int queued_total = 0;
  int accepted_total = 0;
  int errors = 0;
  bit in_fire = 1'b0;
  bit quiet = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  int holds_asked = 0;
  int holds_done = 0;

  function automatic eia_pkg::rsp_t apply_request(eia_pkg::req_t r);
    eia_pkg::rsp_t rsp;
    int slots;
    int e;
    rsp = '0;
    rsp.status = eia_pkg::ST_DONE;
    case (r.operation)
      eia_pkg::OP_CREATE: begin
        slots = (slot_limit == 0 || slot_limit > eia_pkg::MAX_ENTITIES)
                ? eia_pkg::MAX_ENTITIES : int'(slot_limit);
        e = -1;
        if (free_depth > 0) begin
          free_depth--;
          e = free_ids[free_depth];
        end else if (high_water < slots) begin
          e = high_water;
          high_water++;
        end
        if (e >= 0) begin
          comp_mask[e] = '0;
          live_count++;
          rsp.entity_id = eia_pkg::ID_W'(e);
        end else begin
          rsp.status = eia_pkg::ST_FULL;
        end
      end
      eia_pkg::OP_DESTROY: begin
        if (r.entity >= high_water || comp_mask[r.entity] == '0 || live_count == 0 ||
            free_depth >= eia_pkg::MAX_ENTITIES) begin
          rsp.status = eia_pkg::ST_IGNORED;
        end else begin
          comp_mask[r.entity] = '0;
          free_ids[free_depth] = r.entity;
          free_depth++;
          live_count--;
        end
      end
      eia_pkg::OP_RESET: begin
        free_depth = 0;
        high_water = 0;
        live_count = 0;
      end
      default: begin
        if (r.entity >= high_water) begin
          rsp.status = eia_pkg::ST_IGNORED;
        end else begin
          comp_mask[r.entity] = r.mask_value;
        end
      end
    endcase
    rsp.alive_count = eia_pkg::CNT_W'(live_count);
    return rsp;
  endfunction

  // Response check first, then request acceptance and prediction.
  always @(posedge clk) begin
    eia_pkg::rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_rsp.size() == 0) begin
        $display("%0t: response with none expected: actual %p", $time, out_data);
        errors++;
      end else begin
        want = awaited_rsp.pop_front();
        if (out_data.entity_id !== want.entity_id) begin
          $display("%0t: entity_id mismatch: expected %0d, actual %0d",
                   $time, want.entity_id, out_data.entity_id);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, out_data.status);
          errors++;
        end
        if (out_data.alive_count !== want.alive_count) begin
          $display("%0t: alive_count mismatch: expected %0d, actual %0d",
                   $time, want.alive_count, out_data.alive_count);
          errors++;
        end
      end
    end
    in_fire = rst_n && in_valid && !in_stall;
    if (in_fire) begin
      awaited_rsp.push_back(apply_request(in_data));
      accepted_total++;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (req_queue.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        gap_left = $urandom_range(0, 4);
      end else begin
        in_data <= req_queue.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (holds_done != holds_asked) begin
      out_stall <= 1'b1;
      hold_left = 80;
      holds_done++;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic push_req(input logic [1:0] op, input logic [eia_pkg::ID_W-1:0] ent,
                          input logic [eia_pkg::MASK_W-1:0] mval);
    eia_pkg::req_t r;
    r.operation = op;
    r.entity = ent;
    r.mask_value = mval;
    req_queue.push_back(r);
    queued_total++;
  endtask

  task automatic drain();
    while (!(accepted_total == queued_total && awaited_rsp.size() == 0))
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [eia_pkg::CNT_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    slot_limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count, input int bound);
    int k;
    logic [eia_pkg::ID_W-1:0] ent;
    logic [eia_pkg::MASK_W-1:0] mval;
    repeat (count) begin
      k = $urandom_range(0, 99);
      ent = ($urandom_range(0, 9) == 0)
            ? eia_pkg::ID_W'($urandom_range(0, eia_pkg::MAX_ENTITIES - 1))
            : eia_pkg::ID_W'($urandom_range(0, bound));
      mval = ($urandom_range(0, 7) == 0) ? '0 : $urandom;
      if (k < 35) begin
        push_req(eia_pkg::OP_CREATE, eia_pkg::ID_W'($urandom), $urandom);
      end else if (k < 60) begin
        push_req(eia_pkg::OP_SET_MASK, ent, mval);
        push_req(eia_pkg::OP_DESTROY, ent, $urandom);
      end else if (k < 75) begin
        push_req(eia_pkg::OP_DESTROY, ent, $urandom);
      end else if (k < 97) begin
        push_req(eia_pkg::OP_SET_MASK, ent, mval);
      end else begin
        push_req(eia_pkg::OP_RESET, eia_pkg::ID_W'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    logic [eia_pkg::CNT_W-1:0] caps [9];
    int slots;
    caps = '{11'd1, 11'd3, 11'd16, 11'd2, 11'd2047, 11'd1024, 11'd1025, 11'd40, 11'd5};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    push_req(eia_pkg::OP_DESTROY, 10'd0, '0);
    push_req(eia_pkg::OP_SET_MASK, 10'd0, 32'hFFFF_FFFF);
    push_req(eia_pkg::OP_CREATE, 10'd0, '0);
    push_req(eia_pkg::OP_CREATE, 10'd0, '0);
    push_req(eia_pkg::OP_CREATE, 10'd0, '0);
    push_req(eia_pkg::OP_SET_MASK, 10'd1, 32'hFFFF_FFFF);
    push_req(eia_pkg::OP_DESTROY, 10'd1, '0);
    push_req(eia_pkg::OP_DESTROY, 10'd1, '0);
    push_req(eia_pkg::OP_SET_MASK, 10'd1, 32'h8000_0000);
    push_req(eia_pkg::OP_DESTROY, 10'd1023, 32'hFFFF_FFFF);
    push_req(eia_pkg::OP_SET_MASK, 10'd1023, 32'h0000_0001);
    push_req(eia_pkg::OP_CREATE, 10'd1023, 32'hFFFF_FFFF);
    push_req(eia_pkg::OP_SET_MASK, 10'd2, '0);
    push_req(eia_pkg::OP_DESTROY, 10'd2, '0);
    push_req(eia_pkg::OP_RESET, 10'd0, '0);
    push_req(eia_pkg::OP_CREATE, 10'd0, '0);
    push_req(eia_pkg::OP_SET_MASK, 10'd0, 32'h5);
    push_req(eia_pkg::OP_DESTROY, 10'd0, '0);
    push_req(eia_pkg::OP_SET_MASK, 10'd0, 32'h7);
    push_req(eia_pkg::OP_DESTROY, 10'd0, '0);
    push_req(eia_pkg::OP_RESET, 10'd1023, 32'hFFFF_FFFF);
    drain();

    foreach (caps[i]) begin
      write_capacity(caps[i]);
      slots = (caps[i] == 0 || caps[i] > eia_pkg::MAX_ENTITIES)
              ? eia_pkg::MAX_ENTITIES : int'(caps[i]);
      if (i == 2) holds_asked++;
      if (i == 5) begin
        run_random(20, (slots < 48) ? slots : 48);
        drain();
        run_random(20, (slots < 48) ? slots : 48);
      end else begin
        run_random(40, (slots < 48) ? slots : 48);
      end
      drain();
    end

    write_capacity(11'd0);
    quiet = 1'b1;
    push_req(eia_pkg::OP_RESET, 10'd0, '0);
    repeat (500) push_req(eia_pkg::OP_CREATE, eia_pkg::ID_W'($urandom), $urandom);
    push_req(eia_pkg::OP_SET_MASK, 10'd499, 32'hFFFF_FFFF);
    push_req(eia_pkg::OP_DESTROY, 10'd499, '0);
    push_req(eia_pkg::OP_CREATE, 10'd0, '0);
    push_req(eia_pkg::OP_CREATE, 10'd0, '0);
    drain();
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/eia_pkg.sv
design/eia_ram.sv
design/entity_id_allocator.sv
sim/tb.sv
